/* rtl/core/blg_pkg.sv */
// ----------------------------------------------------------------------------
// blg_pkg
// Shared types, action and status codes for the buffer lease guard.
// ----------------------------------------------------------------------------
package blg_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam logic [31:0] GRACE_RESET     = 32'd100000;

  localparam logic [2:0] ACT_RESERVE = 3'd0;
  localparam logic [2:0] ACT_COMMIT  = 3'd1;
  localparam logic [2:0] ACT_CANCEL  = 3'd2;
  localparam logic [2:0] ACT_ACQUIRE = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BUSY         = 3'd1;
  localparam logic [2:0] ST_GRACE        = 3'd2;
  localparam logic [2:0] ST_MISMATCH     = 3'd3;
  localparam logic [2:0] ST_SATURATED    = 3'd4;
  localparam logic [2:0] ST_NOT_RESERVED = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] now_time;
    logic [63:0] uid_in;
  } blg_in_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  status;
    logic [63:0] uid_now;
    logic [15:0] ref_count;
    logic        reserved_now;
    logic [63:0] publish_time;
  } blg_out_t;

  typedef struct packed {
    logic valid;
    logic fire;
  } blg_ctrl_t;

endpackage

/* rtl/core/blg_in_reg.sv */
// ----------------------------------------------------------------------------
// blg_in_reg
// Input register stage; holds one request transaction until it is evaluated.
// ----------------------------------------------------------------------------
module blg_in_reg import blg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  blg_in_t   in_data_i,
  input  logic      adv_i,
  output blg_ctrl_t ctrl_o,
  output blg_in_t   item_o
);

  logic    valid_q, valid_d;
  blg_in_t data_q;
  logic    load;

  assign in_stall_o = valid_q && !adv_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign ctrl_o.valid = valid_q;
  assign ctrl_o.fire  = valid_q && adv_i;
  assign item_o       = data_q;

endmodule

/* rtl/core/blg_core.sv */
// ----------------------------------------------------------------------------
// blg_core
// Lease state registers and the combinational decision logic for one request.
// ----------------------------------------------------------------------------
module blg_core import blg_pkg::*; #(
  parameter int unsigned CountWidth = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  blg_ctrl_t   ctrl_i,
  input  blg_in_t     item_i,
  output blg_out_t    res_o
);

  logic [31:0]           grace_q;
  logic [63:0]           gen_q, gen_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  rsv_q, rsv_d;
  logic [63:0]           pub_q, pub_d;
  logic [2:0]            status;
  logic [63:0]           elapsed;
  logic                  in_grace;
  logic [31:0]           cnt_ext;

  assign elapsed  = item_i.now_time - pub_q;
  assign in_grace = (pub_q != 64'd0) &&
                    ((item_i.now_time < pub_q) || (elapsed < {32'd0, grace_q}));

  always_comb begin
    gen_d  = gen_q;
    cnt_d  = cnt_q;
    rsv_d  = rsv_q;
    pub_d  = pub_q;
    status = ST_OK;
    unique case (item_i.action) inside
      ACT_RESERVE: begin
        if (rsv_q || (cnt_q != '0)) begin
          status = ST_BUSY;
        end else if (in_grace) begin
          status = ST_GRACE;
        end else begin
          rsv_d = 1'b1;
          gen_d = (gen_q == '1) ? 64'd1 : gen_q + 64'd1;
          pub_d = 64'd0;
        end
      end
      ACT_COMMIT, ACT_CANCEL: begin
        if (gen_q != item_i.uid_in) begin
          status = ST_MISMATCH;
        end else if (!rsv_q) begin
          status = ST_NOT_RESERVED;
        end else begin
          rsv_d = 1'b0;
          if (item_i.action == ACT_COMMIT) begin
            pub_d = item_i.now_time;
          end
        end
      end
      ACT_ACQUIRE: begin
        if (gen_q != item_i.uid_in) begin
          status = ST_MISMATCH;
        end else if (rsv_q) begin
          status = ST_BUSY;
        end else if (cnt_q == '1) begin
          status = ST_SATURATED;
        end else begin
          cnt_d = cnt_q + CountWidth'(1);
        end
      end
      ACT_RELEASE: begin
        if (rsv_q) begin
          status = ST_BUSY;
        end else if (cnt_q != '0) begin
          cnt_d = cnt_q - CountWidth'(1);
        end
      end
      default: status = ST_BUSY;
    endcase
  end

  assign cnt_ext = 32'(cnt_d);

  always_comb begin
    res_o.ok           = (status == ST_OK);
    res_o.status       = status;
    res_o.uid_now      = gen_d;
    res_o.ref_count    = cnt_ext[15:0];
    res_o.reserved_now = rsv_d;
    res_o.publish_time = pub_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grace_q <= GRACE_RESET;
    end else if (cfg_valid_i) begin
      grace_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= 64'd0;
      cnt_q <= '0;
      rsv_q <= 1'b0;
      pub_q <= 64'd0;
    end else if (ctrl_i.fire) begin
      gen_q <= gen_d;
      cnt_q <= cnt_d;
      rsv_q <= rsv_d;
      pub_q <= pub_d;
    end
  end

  // readers and a pending reservation exclude each other
  a_rsv_no_readers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rsv_q && (cnt_q != '0)))
    else $error("reservation held while readers present");

  a_rsv_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsv_q |-> (gen_q != 64'd0))
    else $error("reservation with zero generation id");

  a_reserve_clears_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.fire && (item_i.action == ACT_RESERVE) && (status == ST_OK))
      |=> (rsv_q && (pub_q == 64'd0)))
    else $error("reserve did not take effect");

  a_refused_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.fire && (status != ST_OK))
      |=> ($stable(gen_q) && $stable(cnt_q) && $stable(rsv_q) && $stable(pub_q)))
    else $error("refused request changed lease state");

endmodule

/* rtl/core/blg_out_reg.sv */
// ----------------------------------------------------------------------------
// blg_out_reg
// Result register; holds one response transaction while the receiver stalls.
// ----------------------------------------------------------------------------
module blg_out_reg import blg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  blg_ctrl_t ctrl_i,
  input  blg_out_t  res_i,
  output logic      adv_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output blg_out_t  out_data_o
);

  logic     valid_q, valid_d;
  blg_out_t data_q;

  assign adv_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.fire) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* rtl/core/buffer_lease_guard_top.sv */
// ----------------------------------------------------------------------------
// buffer_lease_guard_top
// Lease guard for one shared buffer: writer reserve/commit/cancel and reader
// acquire/release against a generation id, reader count and publish time.
//
// Request channel (in_valid_i / in_stall_o / in_data_i) carries one action
// per transaction; response channel (out_valid_o / out_stall_i / out_data_o)
// returns exactly one result per request, in order. A transaction moves at
// an edge with valid high and stall low.
// Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the grace
// period in microseconds; ready is always high. Write only while idle.
// A request waits in the input register; its result is registered in the
// result register. Throughput: one request per cycle while out_stall_i is
// low, set by the single evaluate-and-update pass on the state registers.
// Reset clears the id, count, flag and publish time and loads a grace
// period of 100000 us. While the receiver stalls, the result register and
// the input register each hold one transaction; once both are full the
// request channel stalls.
// ----------------------------------------------------------------------------
module buffer_lease_guard_top import blg_pkg::*; #(
  parameter int unsigned CountWidth = COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  blg_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output blg_out_t    out_data_o
);

  blg_ctrl_t ctrl;
  blg_in_t   item;
  blg_out_t  res;
  logic      adv;

  assign cfg_ready_o = 1'b1;

  blg_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .adv_i      (adv),
    .ctrl_o     (ctrl),
    .item_o     (item)
  );

  blg_core #(
    .CountWidth (CountWidth)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .item_i      (item),
    .res_o       (res)
  );

  blg_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* bench/tb_buffer_lease_guard_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_buffer_lease_guard_top
// Self-checking bench for the buffer lease guard. A queue-fed driver offers
// lease requests with random gaps and a monitor takes results with random
// stalls. Each accepted request is run through a local lease predictor, and
// every result is checked field by field against the oldest prediction.
// Stimulus covers directed corner cases, a long receiver hold-off, and random
// writer/reader sequences under several grace periods.
// ----------------------------------------------------------------------------
module tb_buffer_lease_guard_top;
  import blg_pkg::*;

  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned TAIL_CYCLES  = 6;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned PHASE_ITEMS  = 280;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam logic [31:0] COUNT_MAX    = (32'd1 << COUNT_WIDTH_DEF) - 32'd1;
  localparam logic [2:0]  ACT_SPARE_LO = 3'd5;
  localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
  localparam logic [63:0] ALL_ONES     = {64{1'b1}};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  blg_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  blg_out_t    out_data_o;

  // predictor state
  logic [63:0] lease_gen     = '0;
  logic [31:0] lease_readers = '0;
  logic        lease_rsv     = 1'b0;
  logic [63:0] lease_pub     = '0;
  logic [31:0] lease_grace   = GRACE_RESET;

  blg_in_t     req_q[$];
  blg_out_t    lease_expect_q[$];

  int unsigned cycles     = 0;
  int unsigned mismatches = 0;
  int unsigned planned    = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  logic        in_fire    = 1'b0;
  logic        tx_idle    = 1'b1;
  logic        rx_idle    = 1'b1;
  logic        rx_hold    = 1'b0;
  logic        hold_go    = 1'b0;

  buffer_lease_guard_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic blg_out_t lease_step(input blg_in_t req);
    blg_out_t   res;
    logic [2:0] st;
    st = ST_OK;
    case (req.action)
      ACT_RESERVE: begin
        if (lease_rsv || lease_readers != 0) begin
          st = ST_BUSY;
        end else if (lease_pub != 0 && (req.now_time < lease_pub ||
                     req.now_time - lease_pub < {32'd0, lease_grace})) begin
          st = ST_GRACE;
        end else begin
          lease_rsv = 1'b1;
          lease_gen = (lease_gen == ALL_ONES) ? 64'd1 : lease_gen + 64'd1;
          lease_pub = '0;
        end
      end
      ACT_COMMIT, ACT_CANCEL: begin
        if (lease_gen != req.uid_in) begin
          st = ST_MISMATCH;
        end else if (!lease_rsv) begin
          st = ST_NOT_RESERVED;
        end else begin
          if (req.action == ACT_COMMIT) lease_pub = req.now_time;
          lease_rsv = 1'b0;
        end
      end
      ACT_ACQUIRE: begin
        if (lease_gen != req.uid_in) st = ST_MISMATCH;
        else if (lease_rsv) st = ST_BUSY;
        else if (lease_readers >= COUNT_MAX) st = ST_SATURATED;
        else lease_readers = lease_readers + 32'd1;
      end
      ACT_RELEASE: begin
        if (lease_rsv) st = ST_BUSY;
        else if (lease_readers != 0) lease_readers = lease_readers - 32'd1;
      end
      default: st = ST_BUSY;
    endcase
    res.ok           = (st == ST_OK);
    res.status       = st;
    res.uid_now      = lease_gen;
    res.ref_count    = lease_readers[15:0];
    res.reserved_now = lease_rsv;
    res.publish_time = lease_pub;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < MAX_REPORTS)
      $display("%0t: %s got %h want %h", $time, field, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk_i) begin
    in_fire = rst_ni && in_valid_i && !in_stall_o;
    if (in_fire) lease_expect_q.push_back(lease_step(in_data_i));
  end

  always @(negedge clk_i) begin
    if (in_fire || !in_valid_i) begin
      if (in_fire) begin
        gap_left = tx_idle ? $urandom_range(0, 8) : 0;
        in_fire  = 1'b0;
      end
      if (gap_left != 0 || req_q.size() == 0 || !rst_ni) begin
        if (gap_left != 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_data_i  <= req_q.pop_front();
        in_valid_i <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : result_monitor
    blg_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_left = rx_idle ? $urandom_range(0, 8) : 0;
      if (lease_expect_q.size() == 0) begin
        report_mismatch("unexpected transaction, uid_now", out_data_o.uid_now, '0);
      end else begin
        want = lease_expect_q.pop_front();
        if (out_data_o.ok !== want.ok)
          report_mismatch("ok", out_data_o.ok, want.ok);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.uid_now !== want.uid_now)
          report_mismatch("uid_now", out_data_o.uid_now, want.uid_now);
        if (out_data_o.ref_count !== want.ref_count)
          report_mismatch("ref_count", out_data_o.ref_count, want.ref_count);
        if (out_data_o.reserved_now !== want.reserved_now)
          report_mismatch("reserved_now", out_data_o.reserved_now, want.reserved_now);
        if (out_data_o.publish_time !== want.publish_time)
          report_mismatch("publish_time", out_data_o.publish_time, want.publish_time);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_hold;
    end
  end

  initial begin : rx_hold_off
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] reserve_time();
    case ($urandom_range(0, 5))
      0:       return rand64();
      1:       return lease_pub + lease_grace - 64'd1;
      2:       return lease_pub + lease_grace;
      3:       return lease_pub - $urandom_range(1, 16);
      default: return lease_pub + lease_grace + $urandom_range(0, 5000);
    endcase
  endfunction

  task automatic queue_req(input logic [2:0] action, input logic [63:0] now,
                           input logic [63:0] uid);
    blg_in_t req;
    req.action   = action;
    req.now_time = now;
    req.uid_in   = uid;
    req_q.push_back(req);
    planned++;
  endtask

  task automatic requests_taken();
    do @(posedge clk_i); while (req_q.size() != 0 || in_valid_i);
  endtask

  task automatic drain_all();
    requests_taken();
    while (lease_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_grace(input logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    lease_grace = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one short writer, reader or noise sequence built on the current state
  task automatic plan_chunk();
    logic [63:0] t;
    logic [63:0] uid;
    tx_idle = ($urandom_range(0, 4) != 0);
    rx_idle = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (lease_rsv) queue_req(ACT_CANCEL, rand64(), lease_gen);
        if ($urandom_range(0, 3) != 0)
          repeat (lease_readers) queue_req(ACT_RELEASE, rand64(), rand64());
        t = reserve_time();
        queue_req(ACT_RESERVE, t, rand64());
        if ($urandom_range(0, 3) == 0)
          queue_req($urandom_range(0, 1) ? ACT_ACQUIRE : ACT_RELEASE, t, lease_gen + 64'd1);
        uid = lease_gen + 64'd1;
        if ($urandom_range(0, 7) == 0) uid ^= 64'd1 << $urandom_range(0, 63);
        case ($urandom_range(0, 5))
          0:       queue_req(ACT_CANCEL, t, uid);
          1:       queue_req(ACT_COMMIT, 64'd0, uid);
          2:       queue_req(ACT_COMMIT, rand64(), uid);
          default: queue_req(ACT_COMMIT, t + $urandom_range(0, 200000), uid);
        endcase
      end
      4, 5, 6: begin
        repeat ($urandom_range(1, 4))
          queue_req(ACT_ACQUIRE, rand64(),
                    ($urandom_range(0, 9) == 0) ? rand64() : lease_gen);
        repeat ($urandom_range(0, 5)) queue_req(ACT_RELEASE, rand64(), rand64());
      end
      default: begin
        repeat ($urandom_range(3, 6))
          queue_req(3'($urandom_range(0, 7)), rand64(),
                    $urandom_range(0, 1) ? rand64() : lease_gen);
      end
    endcase
    requests_taken();
  endtask

  initial begin : stimulus
    logic [31:0] grace_plan [4];
    int unsigned goal;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_req(ACT_RELEASE, 64'd0, 64'd0);
    queue_req(ACT_COMMIT, ALL_ONES, 64'd0);
    queue_req(ACT_CANCEL, 64'd0, ALL_ONES);
    queue_req(ACT_ACQUIRE, 64'd0, 64'd7);
    queue_req(ACT_SPARE_LO, ALL_ONES, ALL_ONES);
    queue_req(ACT_SPARE_HI, ALL_ONES, ALL_ONES);
    queue_req(ACT_RESERVE, ALL_ONES, 64'd0);
    queue_req(ACT_RESERVE, ALL_ONES, 64'd1);
    queue_req(ACT_ACQUIRE, 64'd0, 64'd1);
    queue_req(ACT_RELEASE, 64'd0, 64'd1);
    queue_req(ACT_COMMIT, 64'd5, 64'd0);
    // commit at time zero leaves the buffer marked as never published
    queue_req(ACT_COMMIT, 64'd0, 64'd1);
    queue_req(ACT_RESERVE, 64'd0, 64'd0);
    queue_req(ACT_COMMIT, 64'd1000, 64'd2);
    queue_req(ACT_RESERVE, 64'd999, 64'd0);
    queue_req(ACT_RESERVE, 64'd1000 + GRACE_RESET - 64'd1, 64'd0);
    queue_req(ACT_ACQUIRE, ALL_ONES, 64'd2);
    queue_req(ACT_ACQUIRE, 64'd0, 64'd2);
    queue_req(ACT_RESERVE, 64'd1000 + GRACE_RESET, 64'd0);
    queue_req(ACT_RELEASE, 64'd0, 64'd0);
    queue_req(ACT_RELEASE, 64'd0, 64'd0);
    queue_req(ACT_RELEASE, 64'd0, 64'd0);
    queue_req(ACT_RESERVE, 64'd1000 + GRACE_RESET, 64'd0);
    queue_req(ACT_CANCEL, ALL_ONES, 64'd3);
    queue_req(ACT_RESERVE, 64'd5, 64'd0);
    queue_req(ACT_CANCEL, 64'd0, 64'd4);
    drain_all();

    // receiver holds off while the sender keeps offering back to back
    tx_idle = 1'b0;
    hold_go = 1'b1;
    repeat (12) queue_req(ACT_ACQUIRE, rand64(), lease_gen);
    repeat (12) queue_req(ACT_RELEASE, rand64(), rand64());
    drain_all();

    grace_plan[0] = 32'd0;
    grace_plan[1] = 32'hFFFF_FFFF;
    grace_plan[2] = $urandom_range(1, 200000);
    grace_plan[3] = GRACE_RESET;
    for (int p = 0; p < 4; p++) begin
      drain_all();
      write_grace(grace_plan[p]);
      goal = planned + PHASE_ITEMS;
      while (planned < goal) plan_chunk();
    end

    // closing reader and writer requests back to back
    drain_all();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    if (lease_rsv) begin
      queue_req(ACT_CANCEL, 64'd0, lease_gen);
      requests_taken();
    end
    queue_req(ACT_ACQUIRE, rand64(), lease_gen);
    queue_req(ACT_RELEASE, rand64(), rand64());
    queue_req(ACT_ACQUIRE, rand64(), lease_gen);
    queue_req(ACT_ACQUIRE, rand64(), lease_gen);
    queue_req(ACT_RESERVE, rand64(), rand64());
    queue_req(ACT_RELEASE, rand64(), rand64());
    drain_all();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
